>>> rtl/sal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants of the shifting array list
// request and status codes, field widths, controller/datapath signal groups
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 2;
  localparam int CNT_W  = 7;
  localparam int LIM_W  = 7;

  localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COMPARE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;      // latch accepted item
    logic rd_pos;    // read entry at position
    logic rd_shift;  // read neighbor of pointer
    logic wr_shift;  // write moved entry at pointer, step pointer
    logic wr_pos;    // write value at position
    logic finish;    // commit count, load result register
  } sal_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic             ok;
    logic             more;      // shift needed at start
    logic             last;      // current shift step is the final one
    logic             out_free;
  } sal_sts_t;

endpackage

`default_nettype wire

>>> rtl/sal_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_req_if: request channel
// valid/ready handshake carrying one list request item
// ----------------------------------------------------------------------------
interface sal_req_if;
  import sal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/sal_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_rsp_if: result channel
// valid/ready handshake carrying one list result item
// ----------------------------------------------------------------------------
interface sal_rsp_if;
  import sal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic signed [VAL_W-1:0] read_value;
  logic                    is_match;
  logic [CNT_W-1:0]        entry_count;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, output status, output read_value, output is_match,
                  output entry_count, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input status, input read_value, input is_match,
                  input entry_count, input is_empty, input is_full,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/sal_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_ctrl: request sequencer
// steps each request through decode, entry moves, write and result hand-off
// ----------------------------------------------------------------------------
module sal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sal_pkg::sal_sts_t sts,
  output sal_pkg::sal_cmd_t      cmd
);
  import sal_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SHRD  = 6'b000100,
    S_SHWR  = 6'b001000,
    S_WRITE = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.ok) begin
          state_nxt = S_RESP;
        end else begin
          case (sts.op)
            REQ_INSERT:  state_nxt = sts.more ? S_SHRD : S_WRITE;
            REQ_REMOVE:  state_nxt = sts.more ? S_SHRD : S_RESP;
            REQ_REPLACE: state_nxt = S_WRITE;
            REQ_READ, REQ_COMPARE: begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_RESP;
            end
            default:     state_nxt = S_RESP;
          endcase
        end
      end
      S_SHRD: begin
        cmd.rd_shift = 1'b1;
        state_nxt    = S_SHWR;
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        if (sts.last) begin
          state_nxt = (sts.op == REQ_INSERT) ? S_WRITE : S_RESP;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_WRITE: begin
        cmd.wr_pos = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sal_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sal_dp: list datapath
// entry memory, count, limit register, move pointer and result register
// ----------------------------------------------------------------------------
module sal_dp #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sal_pkg::LIM_W-1:0]      cfg_data,
  input  wire logic [sal_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [sal_pkg::POS_W-1:0]      in_position,
  input  wire logic signed [sal_pkg::VAL_W-1:0] in_value,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [sal_pkg::STS_W-1:0]           out_status,
  output logic signed [sal_pkg::VAL_W-1:0]    out_read_value,
  output logic                                out_is_match,
  output logic [sal_pkg::CNT_W-1:0]           out_entry_count,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  input  wire sal_pkg::sal_cmd_t              cmd,
  output sal_pkg::sal_sts_t                   sts
);
  import sal_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic [LIM_W-1:0]     lim_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [REQ_W-1:0]     req_r;
  logic [CMPW-1:0]      pos_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CW-1:0]        ptr_r;
  logic [WORD_BITS-1:0] rdata_r;

  logic                    out_valid_r;
  logic [STS_W-1:0]        out_status_r;
  logic signed [VAL_W-1:0] out_read_value_r;
  logic                    out_is_match_r;
  logic [CNT_W-1:0]        out_entry_count_r;
  logic                    out_is_empty_r;
  logic                    out_is_full_r;

  logic [CMPW-1:0]      limit;
  logic [CMPW-1:0]      cnt_c;
  logic [STS_W-1:0]     status_c;
  logic                 ok_c;
  logic [CW-1:0]        ptr_dec, ptr_inc;
  logic signed [63:0]   in_ext;
  logic signed [63:0]   rd_ext;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata;

  // effective limit
  always_comb begin
    if (lim_r == '0) begin
      limit = CMPW'(1);
    end else if (CMPW'(lim_r) > CMPW'(CAPACITY)) begin
      limit = CMPW'(CAPACITY);
    end else begin
      limit = CMPW'(lim_r);
    end
  end

  assign cnt_c   = CMPW'(count_r);
  assign ptr_dec = ptr_r - CW'(1);
  assign ptr_inc = ptr_r + CW'(1);
  assign in_ext  = 64'(in_value);
  assign rd_ext  = 64'(signed'(rdata_r));

  always_comb begin
    status_c = ST_OK;
    case (req_r)
      REQ_INSERT: begin
        if (cnt_c >= limit) begin
          status_c = ST_FULL;
        end else if (pos_r > cnt_c) begin
          status_c = ST_RANGE;
        end
      end
      REQ_REMOVE, REQ_REPLACE, REQ_READ, REQ_COMPARE: begin
        if (pos_r >= cnt_c) begin
          status_c = ST_RANGE;
        end
      end
      default: status_c = ST_OK;
    endcase
  end

  assign ok_c = (status_c == ST_OK);

  always_comb begin
    sts          = '0;
    sts.op       = req_r;
    sts.ok       = ok_c;
    sts.out_free = !out_valid_r || out_ready;
    if (req_r == REQ_INSERT) begin
      sts.more = CMPW'(ptr_r) > pos_r;
      sts.last = CMPW'(ptr_dec) == pos_r;
    end else begin
      sts.more = CMPW'(ptr_inc) < cnt_c;
      sts.last = (CMPW'(ptr_inc) + CMPW'(1)) == cnt_c;
    end
  end

  // count after commit
  always_comb begin
    count_nxt = count_r;
    if (ok_c) begin
      case (req_r)
        REQ_INSERT: count_nxt = count_r + CW'(1);
        REQ_REMOVE: count_nxt = count_r - CW'(1);
        REQ_CLEAR:  count_nxt = '0;
        default:    count_nxt = count_r;
      endcase
    end
  end

  // memory port selection
  assign mem_we = cmd.wr_shift || cmd.wr_pos;
  assign mem_re = cmd.rd_shift || cmd.rd_pos;
  assign waddr  = cmd.wr_shift ? ptr_r[AW-1:0] : pos_r[AW-1:0];
  assign wdata  = cmd.wr_shift ? rdata_r : word_r;

  always_comb begin
    if (cmd.rd_pos) begin
      raddr = pos_r[AW-1:0];
    end else if (req_r == REQ_INSERT) begin
      raddr = ptr_dec[AW-1:0];
    end else begin
      raddr = ptr_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // request registers and pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      pos_r  <= CMPW'(in_position);
      word_r <= in_ext[WORD_BITS-1:0];
      ptr_r  <= (in_req_type == REQ_INSERT) ? count_r : CW'(in_position);
    end else if (cmd.wr_shift) begin
      ptr_r  <= (req_r == REQ_INSERT) ? ptr_dec : ptr_inc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r       <= LIM_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lim_r <= cfg_data;
      end
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r      <= status_c;
      out_read_value_r  <= (ok_c && req_r == REQ_READ) ? rd_ext[VAL_W-1:0] : '0;
      out_is_match_r    <= ok_c && (req_r == REQ_COMPARE) && (rdata_r == word_r);
      out_entry_count_r <= CNT_W'(count_nxt);
      out_is_empty_r    <= (count_nxt == '0);
      out_is_full_r     <= CMPW'(count_nxt) >= limit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_is_match    = out_is_match_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_is_full     = out_is_full_r;

endmodule

`default_nettype wire

>>> rtl/shifting_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shifting_array_list: ordered list of signed words in a single-port memory
// steps: decode, then result for read, compare, clear, unused codes, refused requests and
// last-entry remove; replace writes; insert and remove move entries, then insert writes
// throughput: one item at a time, next taken the cycle after its result is loaded,
// which waits while an unaccepted result sits in the output register
// reset: count zero, limit 64; list contents undefined, no clearing pass
// ----------------------------------------------------------------------------
module shifting_array_list #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [sal_pkg::LIM_W-1:0] cfg_data,
  sal_req_if.sink                        in_ch,
  sal_rsp_if.source                      out_ch
);
  import sal_pkg::*;

  sal_cmd_t cmd;
  sal_sts_t sts;

  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sal_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_req_type     (in_ch.req_type),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_read_value  (out_ch.read_value),
    .out_is_match    (out_ch.is_match),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

>>> tb/shifting_array_list_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shifting_array_list_test: self-checking bench for the shifting array list
// directed requests cover empty, front, middle and end positions, range and
// full refusals and odd limit settings; random phases then grow, shrink and
// clear the list under random gaps and output stalls, each result checked
// against a shadow copy of the list kept in the bench
// ----------------------------------------------------------------------------
module shifting_array_list_test;
  import sal_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] read_value;
    logic                    is_match;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
    logic                    is_full;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [LIM_W-1:0]    cfg_data;

  sal_req_if req_ch ();
  sal_rsp_if rsp_ch ();

  shifting_array_list uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch)
  );

  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int unsigned             list_len;
  logic [LIM_W-1:0]        limit_reg;
  list_result_t            pending_results [$];
  int                      mismatch_count;
  bit                      steady_flow;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int unsigned cap_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > LIST_DEPTH) return LIST_DEPTH;
    return 32'(limit_reg);
  endfunction

  function automatic list_result_t apply_request(input logic [REQ_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  lim;
    int unsigned  p;
    int unsigned  i;
    lim = cap_limit();
    p = 32'(pos);
    r = '0;
    case (op)
      REQ_INSERT: begin
        if (list_len >= lim) begin
          r.status = ST_FULL;
        end else if (p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_REPLACE: begin
        if (p >= list_len) r.status = ST_RANGE;
        else list_mem[p] = val;
      end
      REQ_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[p];
      end
      REQ_COMPARE: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.is_match = (list_mem[p] == val);
      end
      REQ_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_W'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full = (list_len >= lim);
    return r;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.position <= pos;
    req_ch.value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(apply_request(op, pos, val));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIM_W-1:0] lim);
    cfg_we <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    limit_reg = lim;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  // list starts empty with the reset limit of 64
  task automatic test_basic_requests();
    send_request(REQ_READ, 0, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_INSERT, 1, 5);
    send_request(REQ_INSERT, 0, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 0, 32'sh8000_0000);
    send_request(REQ_INSERT, 2, -32'sd1);
    send_request(REQ_INSERT, 1, 0);
    send_request(REQ_INSERT, 5, 7);
    send_request(REQ_READ, 0, 0);
    send_request(REQ_READ, 1, 0);
    send_request(REQ_READ, 2, 0);
    send_request(REQ_READ, 3, 0);
    send_request(REQ_READ, 4, 0);
    send_request(REQ_COMPARE, 1, 0);
    send_request(REQ_COMPARE, 2, 5);
    send_request(REQ_COMPARE, 4, -32'sd1);
    send_request(REQ_REPLACE, 2, 32'sh5a5a_5a5a);
    send_request(REQ_REPLACE, 9, 1);
    send_request(REQ_READ, 2, 0);
    send_request(REQ_SPARE_LO, 0, 3);
    send_request(REQ_SPARE_HI, 127, -32'sd1);
    send_request(REQ_REMOVE, 3, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, 50, 0);
    send_request(REQ_CLEAR, 0, 0);
    send_request(REQ_READ, 0, 0);
  endtask

  // limit of one and zero, full store, limit dropped below the count
  task automatic test_limit_edges();
    int k;
    wait_idle();
    set_limit(1);
    send_request(REQ_INSERT, 0, 11);
    send_request(REQ_INSERT, 0, 12);
    send_request(REQ_INSERT, 5, 13);
    send_request(REQ_REMOVE, 0, 0);
    wait_idle();
    set_limit(0);
    send_request(REQ_INSERT, 0, 21);
    send_request(REQ_INSERT, 1, 22);
    send_request(REQ_CLEAR, 0, 0);
    wait_idle();
    set_limit(127);
    for (k = 0; k < LIST_DEPTH; k++) begin
      send_request(REQ_INSERT, POS_W'($urandom_range(0, list_len)), $urandom());
    end
    send_request(REQ_INSERT, 0, 1);
    send_request(REQ_INSERT, 100, 1);
    send_request(REQ_READ, 63, 0);
    send_request(REQ_COMPARE, 63, list_mem[63]);
    wait_idle();
    set_limit(10);
    send_request(REQ_INSERT, 0, 1);
    send_request(REQ_READ, 63, 0);
    while (list_len > 9) begin
      send_request(REQ_REMOVE, POS_W'($urandom_range(0, list_len - 1)), 0);
    end
    send_request(REQ_INSERT, POS_W'(list_len), 31);
    send_request(REQ_INSERT, 0, 32);
  endtask

  task automatic random_phase(input int n, input int grow, input bit allow_clear);
    int k;
    int r;
    logic [REQ_W-1:0]        op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < grow) begin
        op = REQ_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 28) op = REQ_REMOVE;
        else if (r < 43) op = REQ_REPLACE;
        else if (r < 66) op = REQ_READ;
        else if (r < 91) op = REQ_COMPARE;
        else if (r < 97 || !allow_clear) op = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
        else op = REQ_CLEAR;
      end
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
      else if (op == REQ_INSERT) pos = POS_W'($urandom_range(0, list_len));
      else if (list_len != 0) pos = POS_W'($urandom_range(0, list_len - 1));
      else pos = 0;
      val = pick_value();
      if (op == REQ_COMPARE && pos < list_len && $urandom_range(0, 1)) val = list_mem[pos];
      send_request(op, pos, val);
    end
  endtask

  task automatic test_random_traffic();
    wait_idle();
    set_limit(64);
    random_phase(250, 70, 1'b0);
    wait_idle();
    set_limit(LIM_W'($urandom_range(2, 20)));
    random_phase(200, 55, 1'b1);
    wait_idle();
    set_limit(2);
    random_phase(100, 50, 1'b1);
    wait_idle();
    set_limit(65);
    steady_flow = 1'b1;
    random_phase(200, 60, 1'b1);
    wait_idle();
    steady_flow = 1'b0;
    set_limit(0);
    random_phase(80, 50, 1'b1);
    wait_idle();
    set_limit(LIM_W'($urandom_range(21, 127)));
    random_phase(170, 55, 1'b1);
  endtask

  initial begin : drive_ready
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    list_result_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.read_value = rsp_ch.read_value;
      got.is_match = rsp_ch.is_match;
      got.entry_count = rsp_ch.entry_count;
      got.is_empty = rsp_ch.is_empty;
      got.is_full = rsp_ch.is_full;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result item: status=%0d count=%0d",
                                          got.status, got.entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.read_value !== want.read_value ||
            got.is_match !== want.is_match || got.entry_count !== want.entry_count ||
            got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected sts=%0d rd=%0d match=%0b cnt=%0d empty=%0b full=%0b",
                     want.status, want.read_value, want.is_match, want.entry_count,
                     want.is_empty, want.is_full);
            $display("          actual   sts=%0d rd=%0d match=%0b cnt=%0d empty=%0b full=%0b",
                     got.status, got.read_value, got.is_match, got.entry_count,
                     got.is_empty, got.is_full);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.position = '0;
    req_ch.value = '0;
    steady_flow = 1'b0;
    mismatch_count = 0;
    list_len = 0;
    limit_reg = LIM_RESET;
    foreach (list_mem[k]) list_mem[k] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_basic_requests();
    test_limit_edges();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/sal_pkg.sv
rtl/sal_req_if.sv
rtl/sal_rsp_if.sv
rtl/sal_ctrl.sv
rtl/sal_dp.sv
rtl/shifting_array_list.sv
tb/shifting_array_list_test.sv
